/* src/stc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_pkg
// Shared widths, register indexes and types of the scaler tap coefficient
// generator.
// ----------------------------------------------------------------------------
package stc_pkg;

    // Axis size limit and weight precision
    localparam int MAX_SIZE    = 4096;
    localparam int WEIGHT_BITS = 16;

    // Field widths
    localparam int SIZE_W   = 13;                  // size register
    localparam int IDX_W    = 12;                  // pixel index
    localparam int WEIGHT_W = WEIGHT_BITS + 1;     // weight, 1.0 included
    localparam int PROD_W   = 25;                  // (2i+1)*S for valid items
    localparam int QUO_W    = IDX_W + WEIGHT_BITS; // integer and fraction bits
    localparam int REM_W    = SIZE_W + 1;          // remainder, below 2*D
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SIZE_W;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << WEIGHT_BITS;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTERP_MODE = 2'd2;

    // Interpolation modes
    localparam logic MODE_NEAREST  = 1'b0;
    localparam logic MODE_BILINEAR = 1'b1;

    // Per-item flags that ride along with the divider
    typedef struct packed {
        logic overrun;   // dest_index not below dest_size
        logic zero_tap;  // bilinear clamp to tap 0, no next weight
        logic bilinear;  // item was issued in bilinear mode
    } side_t;

    // Saturate a size register value to MAX_SIZE, zero stays zero
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v > SIZE_W'(MAX_SIZE))
            r = SIZE_W'(MAX_SIZE);
        else
            r = v;
        return r;
    endfunction

endpackage

/* src/scaler_tap_coefficient_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaler_tap_coefficient_generator
// Source tap index and two weights for one destination pixel of a scaled axis.
// ----------------------------------------------------------------------------
// Takes one item per clock while s_tready is high and gives one result per
// item. The input register loads on the edge that accepts an item, followed
// by the (2i+1)*S product register, the pipelined divider (one quotient bit
// per stage, 12 index bits and 16 weight bits) and the output register. A
// two-entry output register lets one more result land while the consumer
// stalls; s_tready drops only once both are full. Sizes are saturated to
// 4096 when written; a zero source size acts as one and a zero destination
// size flags every item as out of range. Write the registers only while no
// item is in flight.
// ----------------------------------------------------------------------------
module scaler_tap_coefficient_generator
    import stc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [11:0] dest_index
    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata,   // [11:0] src_index,
                                             // [28:12] weight_this,
                                             // [45:29] weight_next
    output logic                  m_tuser    // [0] out_of_range
);

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight_next;
        logic [WEIGHT_W-1:0] weight_this;
        logic [IDX_W-1:0]    src_index;
        logic                out_of_range;
    } result_t;

    // Configuration registers, sizes stored saturated
    logic [SIZE_W-1:0] source_size_reg;
    logic [SIZE_W-1:0] dest_size_reg;
    logic              mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_size_reg <= SIZE_W'(1);
            dest_size_reg   <= SIZE_W'(1);
            mode_reg        <= MODE_NEAREST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SOURCE_SIZE: source_size_reg <= clamp_size(cfg_data);
                REG_DEST_SIZE:   dest_size_reg   <= clamp_size(cfg_data);
                REG_INTERP_MODE: mode_reg        <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective source size: zero acts as one
    logic [SIZE_W-1:0] src_eff;
    assign src_eff = (source_size_reg == '0) ? SIZE_W'(1) : source_size_reg;

    // Pipeline enable: stall only when the skid entry is taken
    logic    en;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_reg;
    result_t skid_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // Stage 1: input register
    logic             p1_valid_reg;
    logic [IDX_W-1:0] p1_index_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (en)
            p1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en && s_tvalid)
            p1_index_reg <= s_tdata[IDX_W-1:0];
    end

    // Stage 2: product (2i+1)*S and overrun check
    logic [2*SIZE_W-1:0] prod_full;
    logic                p1_overrun;
    logic                p2_valid_reg;
    logic [PROD_W-1:0]   p2_prod_reg;
    logic                p2_overrun_reg;

    assign prod_full  = {p1_index_reg, 1'b1} * src_eff;
    assign p1_overrun = {1'b0, p1_index_reg} >= dest_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_valid_reg <= 1'b0;
        else if (en)
            p2_valid_reg <= p1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_prod_reg    <= prod_full[PROD_W-1:0];
            p2_overrun_reg <= p1_overrun;
        end
    end

    // Dividend: shift by half a source pixel in bilinear mode
    logic              neg_pos;
    logic [PROD_W-1:0] dividend;
    side_t             div_side_in;

    assign neg_pos  = p2_prod_reg < PROD_W'(dest_size_reg);
    assign dividend = (mode_reg == MODE_BILINEAR)
                    ? PROD_W'(p2_prod_reg - PROD_W'(dest_size_reg))
                    : p2_prod_reg;

    always_comb
    begin
        div_side_in.overrun  = p2_overrun_reg;
        div_side_in.bilinear = (mode_reg == MODE_BILINEAR);
        div_side_in.zero_tap = (mode_reg == MODE_BILINEAR)
                             && (neg_pos || src_eff == SIZE_W'(1));
    end

    // Divide by 2*D
    logic             div_valid;
    side_t            div_side;
    logic [QUO_W-1:0] div_quot;

    stc_divider u_divider (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (p2_valid_reg),
        .in_side     (div_side_in),
        .in_dividend (dividend),
        .den         ({dest_size_reg, 1'b0}),
        .out_valid   (div_valid),
        .out_side    (div_side),
        .out_quot    (div_quot)
    );

    // Boundary rules and weights
    logic [IDX_W-1:0]       q_int;
    logic [WEIGHT_BITS-1:0] q_frac;
    logic [IDX_W-1:0]       res_index;
    logic [WEIGHT_W-1:0]    res_wnext;
    result_t                res;

    assign q_int  = div_quot[QUO_W-1:WEIGHT_BITS];
    assign q_frac = div_quot[WEIGHT_BITS-1:0];

    always_comb
    begin
        res_index = q_int;
        res_wnext = '0;
        if (div_side.bilinear)
        begin
            if (div_side.zero_tap)
            begin
                res_index = '0;
                res_wnext = '0;
            end
            else if ({1'b0, q_int} >= SIZE_W'(src_eff - SIZE_W'(1)))
            begin
                // last pair of taps, all weight on the next one
                res_index = IDX_W'(q_int - IDX_W'(1));
                res_wnext = WEIGHT_ONE;
            end
            else
            begin
                res_index = q_int;
                res_wnext = WEIGHT_W'(q_frac);
            end
        end

        if (div_side.overrun)
        begin
            res.src_index    = '0;
            res.weight_this  = '0;
            res.weight_next  = '0;
            res.out_of_range = 1'b1;
        end
        else
        begin
            res.src_index    = res_index;
            res.weight_this  = WEIGHT_W'(WEIGHT_ONE - res_wnext);
            res.weight_next  = res_wnext;
            res.out_of_range = 1'b0;
        end
    end

    // Output register with one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_tready)
                skid_valid_reg <= 1'b0;
        end
        else if (div_valid)
        begin
            if (out_valid_reg && !m_tready)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_tready)
                out_reg <= skid_reg;
        end
        else if (div_valid)
        begin
            if (out_valid_reg && !m_tready)
                skid_reg <= res;
            else
                out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.weight_next, out_reg.weight_this, out_reg.src_index};
    assign m_tuser  = out_reg.out_of_range;

`ifndef ASSERT_OFF
    // The skid entry is only ever filled behind a waiting result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid without output valid");

    // An in-range result has weights summing to exactly one
    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.out_of_range) |->
        ({1'b0, out_reg.weight_this} + {1'b0, out_reg.weight_next}
            == {1'b0, WEIGHT_ONE}))
        else $error("weights do not sum to one");

    // An overrun result carries zero fields
    a_overrun_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.out_of_range) |->
        (out_reg.src_index == '0 && out_reg.weight_this == '0
            && out_reg.weight_next == '0))
        else $error("overrun result with nonzero fields");

    // A stalled skid entry blocks the input the next cycle as well
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !m_tready) |=> !s_tready)
        else $error("input accepted while skid entry still full");
`endif

endmodule

/* src/stc_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_divider
// Pipelined restoring divider: one quotient bit per stage. Gives
// floor(dividend * 2^WEIGHT_BITS / den), integer part in the top bits.
// ----------------------------------------------------------------------------
module stc_divider
    import stc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  side_t             in_side,
    input  logic [PROD_W-1:0] in_dividend,
    input  logic [REM_W-1:0]  den,
    output logic              out_valid,
    output side_t             out_side,
    output logic [QUO_W-1:0]  out_quot
);

    // Stage registers: entry k holds the state after k+1 steps
    logic              valid_reg [QUO_W];
    side_t             side_reg  [QUO_W];
    logic [REM_W-1:0]  rem_reg   [QUO_W];
    logic [IDX_W-1:0]  dlo_reg   [QUO_W];
    logic [QUO_W-1:0]  quot_reg  [QUO_W];

    // Stage inputs
    logic              valid_in  [QUO_W];
    side_t             side_in   [QUO_W];
    logic [REM_W-1:0]  rem_in    [QUO_W];
    logic [IDX_W-1:0]  dlo_in    [QUO_W];
    logic [QUO_W-1:0]  quot_in   [QUO_W];

    // Next values
    logic [REM_W-1:0]  rem_next  [QUO_W];
    logic [IDX_W-1:0]  dlo_next  [QUO_W];
    logic [QUO_W-1:0]  quot_next [QUO_W];

    // Chain the stages; the first one takes the upper dividend bits
    always_comb
    begin
        valid_in[0] = in_valid;
        side_in[0]  = in_side;
        rem_in[0]   = REM_W'(in_dividend[PROD_W-1:IDX_W]);
        dlo_in[0]   = in_dividend[IDX_W-1:0];
        quot_in[0]  = '0;
        for (int k = 1; k < QUO_W; k++)
        begin
            valid_in[k] = valid_reg[k-1];
            side_in[k]  = side_reg[k-1];
            rem_in[k]   = rem_reg[k-1];
            dlo_in[k]   = dlo_reg[k-1];
            quot_in[k]  = quot_reg[k-1];
        end
    end

    // One compare and subtract per stage; zeros shift in after the integer bits
    always_comb
    begin
        for (int k = 0; k < QUO_W; k++)
        begin
            logic [REM_W:0] trial;
            logic           ge;
            trial = {rem_in[k], dlo_in[k][IDX_W-1]};
            ge    = trial >= {1'b0, den};
            if (ge)
                rem_next[k] = REM_W'(trial - {1'b0, den});
            else
                rem_next[k] = trial[REM_W-1:0];
            dlo_next[k]  = {dlo_in[k][IDX_W-2:0], 1'b0};
            quot_next[k] = {quot_in[k][QUO_W-2:0], ge};
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QUO_W; k++)
                valid_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            for (int k = 0; k < QUO_W; k++)
                valid_reg[k] <= valid_in[k];
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < QUO_W; k++)
            begin
                side_reg[k] <= side_in[k];
                rem_reg[k]  <= rem_next[k];
                dlo_reg[k]  <= dlo_next[k];
                quot_reg[k] <= quot_next[k];
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];
    assign out_quot  = quot_reg[QUO_W-1];

endmodule

/* verif/scaler_tap_coefficient_generator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaler_tap_coefficient_generator_tb
// Self-checking testbench for the scaler tap coefficient generator.
// ----------------------------------------------------------------------------
// Each accepted dest_index is run through an in-bench model of the tap
// arithmetic, using exact integer division with truncated weights. The result
// is queued and compared field by field with the next result item. A short
// directed section covers the size extremes, both modes, saturation, zero
// sizes and the clamp at each edge. Random phases follow, each with a fresh
// axis setting. Sender and receiver gaps vary per phase. One phase holds the
// output off long enough to back the block up to its input.
// ----------------------------------------------------------------------------
module scaler_tap_coefficient_generator_tb;
    import stc_pkg::*;

    localparam int     CLK_HALF         = 4;
    localparam int     RESET_CYCLES     = 7;
    localparam int     RANDOM_PHASES    = 25;
    localparam int     ITEMS_PER_PHASE  = 50;
    localparam int     LONG_STALL_PHASE = 20;
    localparam int     LONG_HOLD_CYCLES = 300;
    localparam int     DRAIN_CYCLES     = 40;
    localparam int     MAX_REPORTS      = 50;
    localparam longint CYCLE_LIMIT      = 200000;

    // Index with no register behind it, writes must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0]    src_index;
        logic [WEIGHT_W-1:0] weight_this;
        logic [WEIGHT_W-1:0] weight_next;
        logic                out_of_range;
    } taps_t;

    // ------------------------------------------------------------------------
    // Tap predictor and queue of expected results
    // ------------------------------------------------------------------------
    class tap_scoreboard;
        logic [SIZE_W-1:0] source_size;
        logic [SIZE_W-1:0] dest_size;
        logic              interp_mode;
        taps_t             expected_q[$];
        int unsigned       mismatches;

        function new();
            source_size = SIZE_W'(1);
            dest_size   = SIZE_W'(1);
            interp_mode = MODE_NEAREST;
            mismatches  = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0]  idx,
                                input logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_SOURCE_SIZE: source_size = val;
                REG_DEST_SIZE:   dest_size   = val;
                REG_INTERP_MODE: interp_mode = val[0];
                default: ;
            endcase
        endfunction

        // Destination size after saturation, zero stays zero
        function longint unsigned dest_span();
            longint unsigned d;
            d = 64'(dest_size);
            if (d > MAX_SIZE)
                d = MAX_SIZE;
            return d;
        endfunction

        function taps_t predict_taps(input logic [IDX_W-1:0] dest_index);
            longint unsigned one;
            longint unsigned s;
            longint unsigned d;
            longint unsigned i;
            longint unsigned num;
            longint unsigned den;
            longint unsigned n;
            longint unsigned fl;
            longint unsigned wn;
            taps_t           t;
            one = 64'd1 << WEIGHT_BITS;
            s   = 64'(source_size);
            if (s > MAX_SIZE)
                s = MAX_SIZE;
            if (s == 0)
                s = 1;
            d  = dest_span();
            i  = 64'(dest_index);
            t  = '0;
            wn = 0;
            if (i >= d)
            begin
                t.out_of_range = 1'b1;
                return t;
            end
            // pixel centers at half steps: position (2i+1)*S/(2D) on the source
            num = (2 * i + 1) * s;
            den = 2 * d;
            if (interp_mode == MODE_NEAREST)
                t.src_index = IDX_W'(num / den);
            else if (s == 1 || num < d)
                t.src_index = '0;   // single tap, or left of the first center
            else
            begin
                n  = num - d;
                fl = n / den;
                if (fl >= s - 1)
                begin
                    // past the last center: lean fully on the last tap
                    t.src_index = IDX_W'(fl - 1);
                    wn = one;
                end
                else
                begin
                    t.src_index = IDX_W'(fl);
                    wn = ((n % den) << WEIGHT_BITS) / den;
                end
            end
            t.weight_next = WEIGHT_W'(wn);
            t.weight_this = WEIGHT_W'(one - wn);
            return t;
        endfunction

        function void note_input(input logic [IDX_W-1:0] dest_index);
            expected_q.push_back(predict_taps(dest_index));
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void flag_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
            if (want != got)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, name, want, got);
            end
        endfunction

        function void check_result(input logic [47:0] data, input logic user);
            taps_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with none expected, expected none, actual %h/%b",
                             $time, data, user);
                return;
            end
            want = expected_q.pop_front();
            flag_field("src_index",    64'(want.src_index),    64'(data[11:0]));
            flag_field("weight_this",  64'(want.weight_this),  64'(data[28:12]));
            flag_field("weight_next",  64'(want.weight_next),  64'(data[45:29]));
            flag_field("out_of_range", 64'(want.out_of_range), 64'(user));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT signals and instance
    // ------------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;   // [11:0] dest_index
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [47:0]           m_tdata;          // [11:0] src_index, [28:12] weight_this,
                                             // [45:29] weight_next
    logic                  m_tuser;          // [0] out_of_range

    int unsigned tx_idle_pct   = 0;
    int unsigned rx_idle_pct   = 0;
    logic        long_stall_req = 1'b0;

    tap_scoreboard sb = new();

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    scaler_tap_coefficient_generator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Leaves cfg_we high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    // Sets the axis, then pokes the unmapped index to show it has no effect
    task automatic configure(input logic [SIZE_W-1:0] src_pixels,
                             input logic [SIZE_W-1:0] dst_pixels,
                             input logic              mode);
        write_reg(REG_SOURCE_SIZE, src_pixels);
        write_reg(REG_DEST_SIZE, dst_pixels);
        write_reg(REG_INTERP_MODE, {(CFG_DATA_W-1)'($urandom_range(4095)), mode});
        write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    // Leaves s_tvalid high so back-to-back items need no extra edge
    task automatic send_item(input logic [IDX_W-1:0] dest_index);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, dest_index};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(dest_index);
    endtask

    // Stop offering items and wait for every outstanding result
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    // Mostly ordinary sizes, with zero, tiny, full and oversized values mixed in
    function automatic logic [SIZE_W-1:0] pick_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5)
            return '0;
        if (r < 13)
            return SIZE_W'(1);
        if (r < 21)
            return SIZE_W'(2);
        if (r < 29)
            return SIZE_W'(MAX_SIZE);
        if (r < 35)
            return SIZE_W'($urandom_range(MAX_SIZE + 1, 8191));
        if (r < 60)
            return SIZE_W'($urandom_range(3, 64));
        return SIZE_W'($urandom_range(3, MAX_SIZE));
    endfunction

    // Mostly in-range indexes, both ends favored, some anywhere in the field
    function automatic logic [IDX_W-1:0] pick_index();
        longint unsigned span;
        int unsigned     r;
        span = sb.dest_span();
        r    = $urandom_range(99);
        if (span == 0 || r < 10)
            return IDX_W'($urandom_range(4095));
        if (r < 15)
            return '0;
        if (r < 20)
            return IDX_W'(span - 1);
        return IDX_W'($urandom_range(int'(span) - 1));
    endfunction

    // ------------------------------------------------------------------------
    // Result side: check accepted items, then choose the next tready
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if (long_stall_req && !hold_done)
            begin
                hold_left = LONG_HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Timeout
    initial
    begin : watchdog
        longint unsigned cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_idling(0, 0);

        // Reset setting: one source pixel, one destination pixel, nearest
        send_item(12'd0);
        send_item(12'd1);
        send_item(12'd4095);
        drain();

        // Oversized writes saturate to full size; both ends in bilinear
        configure(13'd8191, 13'd5000, MODE_BILINEAR);
        send_item(12'd0);
        send_item(12'd1);
        send_item(12'd2048);
        send_item(12'd4095);
        drain();

        // Zero source size behaves as a single tap
        configure(13'd0, 13'd7, MODE_BILINEAR);
        send_item(12'd0);
        send_item(12'd3);
        send_item(12'd6);
        send_item(12'd7);
        drain();

        // Heavy upscale: clamp left of the first center and past the last
        configure(13'd2, 13'd4096, MODE_BILINEAR);
        send_item(12'd0);
        send_item(12'd1500);
        send_item(12'd4095);
        drain();

        // Full downscale to one pixel
        configure(13'd4096, 13'd1, MODE_NEAREST);
        send_item(12'd0);
        send_item(12'd1);
        drain();

        // Nearest upscale, last valid index and first overrun
        configure(13'd3, 13'd1000, MODE_NEAREST);
        send_item(12'd0);
        send_item(12'd999);
        send_item(12'd1000);
        drain();

        // Zero destination size: everything overruns
        configure(13'd100, 13'd0, MODE_BILINEAR);
        send_item(12'd0);
        send_item(12'd4095);
        drain();

        // Unity scale at full size
        configure(13'd4096, 13'd4096, MODE_NEAREST);
        send_item(12'd4095);
        send_item(12'd2730);
        drain();

        // Random phases: receiver-heavy gaps, then sender-heavy, then none
        for (int k = 0; k < RANDOM_PHASES; k++)
        begin
            if (k < RANDOM_PHASES / 3)
                set_idling(29, 71);
            else if (k < 2 * RANDOM_PHASES / 3)
                set_idling(71, 29);
            else
                set_idling(0, 0);
            configure(pick_size(), pick_size(), 1'($urandom_range(1)));
            long_stall_req <= (k == LONG_STALL_PHASE);
            for (int j = 0; j < ITEMS_PER_PHASE; j++)
                send_item(pick_index());
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
